// ----- rtl/afx_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the affine transform engine.
package afx_pkg;

  // Default CORDIC iteration count
  localparam int CORDIC_ITER_DEF = 16;

  // Entries held in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Q16.16 unity and angle limits in Q16.16 degrees
  localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
  localparam logic signed [26:0] DEG360  = 27'sd23592960;
  localparam logic signed [26:0] DEG180  = 27'sd11796480;
  localparam logic signed [26:0] DEG90   = 27'sd5898240;

  // CORDIC limit gain in Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    KIND_TRANSLATE = 2'd0,
    KIND_SCALE     = 2'd1,
    KIND_ROTATE    = 2'd2,
    KIND_POINT     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CORDIC,
    B_STEP,
    B_MAT,
    B_PT,
    B_EMIT
  } back_state_t;

  // Classified command: operands packed by kind
  //   translate: a=tx b=ty        scale: a=sx b=sy c=ref_x d=ref_y
  //   rotate:    c=ref_x d=ref_y z=reduced angle, flip=negate sin/cos
  //   point:     a=px b=py
  typedef struct packed {
    kind_t       kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [24:0] z;
    logic        flip;
  } cmd_t;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest
  function automatic logic signed [25:0] atan_q16(input logic [4:0] i);
    logic signed [25:0] v;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Sign-extend a 32-bit value to a 33-bit operand
  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return {v[31], v};
  endfunction

endpackage

// ----- rtl/afx_front.sv -----
// Front end: input register, kind classification and angle reduction.
module afx_front import afx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] tx,
  input  logic [31:0] ty,
  input  logic [31:0] sx,
  input  logic [31:0] sy,
  input  logic [25:0] angle_deg,
  input  logic [31:0] ref_x,
  input  logic [31:0] ref_y,
  input  logic [31:0] px,
  input  logic [31:0] py,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic               f_valid;
  cmd_t               f_cmd;
  cmd_t               cls;
  kind_t              k;
  logic signed [26:0] ang, r1, r2, r3;
  logic               flip;

  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;
  assign push_cmd = f_cmd;

  // Reduce the angle modulo 360 into (-180, 180], then fold into [-90, 90]
  always_comb begin
    ang = {angle_deg[25], angle_deg};
    if (ang >= DEG360) begin
      r1 = ang - DEG360;
    end else if (ang <= -DEG360) begin
      r1 = ang + DEG360;
    end else begin
      r1 = ang;
    end
    if (r1 > DEG180) begin
      r2 = r1 - DEG360;
    end else if (r1 <= -DEG180) begin
      r2 = r1 + DEG360;
    end else begin
      r2 = r1;
    end
    flip = 1'b0;
    if (r2 > DEG90) begin
      r3   = r2 - DEG180;
      flip = 1'b1;
    end else if (r2 < -DEG90) begin
      r3   = r2 + DEG180;
      flip = 1'b1;
    end else begin
      r3 = r2;
    end
  end

  // Pack the operands that the item's kind needs
  always_comb begin
    k        = kind_t'(kind);
    cls      = '0;
    cls.kind = k;
    case (k)
      KIND_TRANSLATE: begin
        cls.a = tx;
        cls.b = ty;
      end
      KIND_SCALE: begin
        cls.a = sx;
        cls.b = sy;
        cls.c = ref_x;
        cls.d = ref_y;
      end
      KIND_ROTATE: begin
        cls.c    = ref_x;
        cls.d    = ref_y;
        cls.z    = r3[24:0];
        cls.flip = flip;
      end
      default: begin
        cls.a = px;
        cls.b = py;
      end
    endcase
  end

  // Hold one transaction until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_valid <= 1'b1;
      f_cmd   <= cls;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/afx_queue.sv -----
// Short command queue between the front and back ends.
module afx_queue import afx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          ent [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = ent[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/afx_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine in Q16.16.
module afx_cordic import afx_pkg::*; #(
  parameter int ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [24:0] z_in,
  input  logic        flip_in,
  output logic        done,
  output logic [31:0] cos_q,
  output logic [31:0] sin_q
);

  localparam int ITW = $clog2(ITERATIONS);

  logic signed [33:0] x, y, dx, dy, xr, yr;
  logic signed [25:0] z, ang;
  logic [ITW-1:0]     it;
  logic               busy;
  logic               flip;

  assign dx  = y >>> it;
  assign dy  = x >>> it;
  assign ang = atan_q16(5'(it));

  // Round Q2.30 to Q16.16 and apply the quadrant fold
  assign xr    = (x + 34'sd8192) >>> 14;
  assign yr    = (y + 34'sd8192) >>> 14;
  assign cos_q = flip ? -xr[31:0] : xr[31:0];
  assign sin_q = flip ? -yr[31:0] : yr[31:0];

  // One micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= {z_in[24], z_in};
        it   <= '0;
        flip <= flip_in;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[25]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end
        it <= it + 1'b1;
        if (it == ITW'(ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/afx_back.sv -----
// Back end: matrix state, shared multiplier sequencer and result register.
module afx_back import afx_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y
);

  back_state_t        state, state_next;
  cmd_t               cur;
  logic [31:0]        mat [6];
  logic [31:0]        t [6];
  logic [31:0]        n [5];
  logic [31:0]        res_x, res_y;
  logic [2:0]         e;
  logic [1:0]         cyc;
  logic               j, last_cyc, work, cor_start, emit_load, phase_end;
  logic               cor_done;
  logic [31:0]        cor_cos, cor_sin;
  logic signed [32:0] op_a, op_b, one_m_c;
  logic signed [65:0] prod;
  logic signed [49:0] prod_q;
  logic signed [51:0] acc, sum;
  logic [31:0]        cst;
  logic               sub;
  logic [31:0]        res;
  logic               row;
  logic [1:0]         col;

  // Start from the queue head: the command register loads on the same edge
  afx_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .z_in    (cmd.z),
    .flip_in (cmd.flip),
    .done    (cor_done),
    .cos_q   (cor_cos),
    .sin_q   (cor_sin)
  );

  assign j        = (cyc != 2'd0);
  assign last_cyc = (cyc == 2'd2);
  assign work     = (state == B_STEP) || (state == B_MAT) || (state == B_PT);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            KIND_TRANSLATE: state_next = B_MAT;
            KIND_SCALE:     state_next = B_STEP;
            KIND_ROTATE:    state_next = B_CORDIC;
            default:        state_next = B_PT;
          endcase
        end
      end
      B_CORDIC: if (cor_done) state_next = B_STEP;
      B_STEP:   if (last_cyc && e == 3'd1) state_next = B_MAT;
      B_MAT:    if (last_cyc && e == 3'd5) state_next = B_IDLE;
      B_PT:     if (last_cyc && e == 3'd1) state_next = B_EMIT;
      B_EMIT:   if (!out_valid || !out_stall) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop   = (state == B_IDLE) && cmd_valid;
    cor_start = cmd_pop && (cmd.kind == KIND_ROTATE);
    emit_load = (state == B_EMIT) && (!out_valid || !out_stall);
    case (state)
      B_STEP:  phase_end = (e == 3'd1);
      B_MAT:   phase_end = (e == 3'd5);
      B_PT:    phase_end = (e == 3'd1);
      default: phase_end = 1'b1;
    endcase
  end

  // Select the multiplier operands and constant term of the current sum
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    cst     = '0;
    sub     = 1'b0;
    one_m_c = ONE_Q16 - sx33(t[0]);
    row     = (e >= 3'd3);
    col     = row ? 2'(e - 3'd3) : 2'(e);
    case (state)
      B_STEP: begin
        if (cur.kind == KIND_SCALE) begin
          if (!j) begin
            op_a = ONE_Q16 - sx33((e == 3'd0) ? cur.a : cur.b);
            op_b = sx33((e == 3'd0) ? cur.c : cur.d);
          end
        end else if (e == 3'd0) begin
          op_a = sx33(j ? cur.d : cur.c);
          op_b = j ? sx33(t[3]) : one_m_c;
        end else begin
          op_a = sx33(j ? cur.c : cur.d);
          op_b = j ? sx33(t[3]) : one_m_c;
          sub  = 1'b1;
        end
      end
      B_MAT: begin
        op_a = sx33(row ? (j ? t[4] : t[3]) : (j ? t[1] : t[0]));
        case (col)
          2'd0:    op_b = sx33(j ? mat[3] : mat[0]);
          2'd1:    op_b = sx33(j ? mat[4] : mat[1]);
          default: op_b = sx33(j ? mat[5] : mat[2]);
        endcase
        if (col == 2'd2) begin
          cst = row ? t[5] : t[2];
        end
      end
      B_PT: begin
        if (e == 3'd0) begin
          op_a = sx33(j ? mat[1] : mat[0]);
          cst  = mat[2];
        end else begin
          op_a = sx33(j ? mat[4] : mat[3]);
          cst  = mat[5];
        end
        op_b = sx33(j ? cur.b : cur.a);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Floor product, final sum and saturation
  assign prod_q = prod[65:16];
  always_comb begin
    if (sub) begin
      sum = acc - {{2{prod_q[49]}}, prod_q};
    end else begin
      sum = acc + {{2{prod_q[49]}}, prod_q};
    end
    if (sum > 52'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (sum < -52'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = sum[31:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      e         <= '0;
      cyc       <= '0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (!work) begin
        e   <= '0;
        cyc <= '0;
      end else if (last_cyc) begin
        cyc <= '0;
        e   <= phase_end ? 3'd0 : e + 3'd1;
      end else begin
        cyc <= cyc + 2'd1;
      end
    end
  end

  // Matrix state, reset to identity
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= 32'h0001_0000;
      mat[1] <= '0;
      mat[2] <= '0;
      mat[3] <= '0;
      mat[4] <= 32'h0001_0000;
      mat[5] <= '0;
    end else if (state == B_MAT && last_cyc && e == 3'd5) begin
      mat[0] <= n[0];
      mat[1] <= n[1];
      mat[2] <= n[2];
      mat[3] <= n[3];
      mat[4] <= n[4];
      mat[5] <= res;
    end
  end

  // Datapath: command, step matrix, multiplier, accumulator, results
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
      case (cmd.kind)
        KIND_TRANSLATE: begin
          t[0] <= 32'h0001_0000;
          t[1] <= '0;
          t[2] <= cmd.a;
          t[3] <= '0;
          t[4] <= 32'h0001_0000;
          t[5] <= cmd.b;
        end
        KIND_SCALE: begin
          t[0] <= cmd.a;
          t[1] <= '0;
          t[3] <= '0;
          t[4] <= cmd.b;
        end
        default: begin
          t[1] <= '0;
        end
      endcase
    end
    if (state == B_CORDIC && cor_done) begin
      t[0] <= cor_cos;
      t[1] <= -cor_sin;
      t[3] <= cor_sin;
      t[4] <= cor_cos;
    end
    prod <= op_a * op_b;
    if (cyc == 2'd1) begin
      acc <= {{20{cst[31]}}, cst} + {{2{prod_q[49]}}, prod_q};
    end
    if (last_cyc) begin
      case (state)
        B_STEP: begin
          if (e == 3'd0) begin
            t[2] <= res;
          end else begin
            t[5] <= res;
          end
        end
        B_MAT: begin
          case (e)
            3'd0:    n[0] <= res;
            3'd1:    n[1] <= res;
            3'd2:    n[2] <= res;
            3'd3:    n[3] <= res;
            3'd4:    n[4] <= res;
            default: n[0] <= n[0];
          endcase
        end
        B_PT: begin
          if (e == 3'd0) begin
            res_x <= res;
          end else begin
            res_y <= res;
          end
        end
        default: begin
          res_x <= res_x;
        end
      endcase
    end
    if (emit_load) begin
      out_x <= res_x;
      out_y <= res_y;
    end
  end

endmodule

// ----- rtl/affine_2d_transform_engine.sv -----
// Top level of the 2D affine transform engine.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid, in_stall | kind, tx, ty, sx, sy, angle_deg, ref_x,
//          |                    | ref_y, px, py
//  output  | out_valid,out_stall| out_x, out_y (point items only)
//
// Each sum of two products runs on the one shared 33x33 multiplier.
// A point item also waits for the output register, and each item passes the
// front register and the queue before it reaches the back end.
// Items are carried out one at a time.
// Reset (rst, synchronous) sets the matrix to identity and empties the queue.
// The front keeps taking transactions while the back works, until the
// queue is full; a stalled result holds in the output register.
module affine_2d_transform_engine import afx_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] tx,
  input  logic [31:0] ty,
  input  logic [31:0] sx,
  input  logic [31:0] sy,
  input  logic [25:0] angle_deg,
  input  logic [31:0] ref_x,
  input  logic [31:0] ref_y,
  input  logic [31:0] px,
  input  logic [31:0] py,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y
);

  logic q_full, push, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  afx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .tx        (tx),
    .ty        (ty),
    .sx        (sx),
    .sy        (sy),
    .angle_deg (angle_deg),
    .ref_x     (ref_x),
    .ref_y     (ref_y),
    .px        (px),
    .py        (py),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  afx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  afx_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y)
  );

endmodule

// ----- rtl/afx_checker.sv -----
// Port-level checker for the affine transform engine and its bind.
module afx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

  // No result straight after reset
  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // The input side is open straight after reset
  a_rst_in: assert property (@(posedge clk) $past(rst) |-> !in_stall)
    else $error("input stalled after reset");

endmodule

bind affine_2d_transform_engine afx_checker u_afx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y)
);
